@@ rtl/core/romaji_to_katakana_converter_defines.svh @@
// ----------------------------------------------------------------------------
// romaji to katakana converter assertion macros
// shared check wrappers, clocked on clk; RKC_ASSERT is quiet during reset
// ----------------------------------------------------------------------------
`ifndef ROMAJI_TO_KATAKANA_CONVERTER_DEFINES_SVH
`define ROMAJI_TO_KATAKANA_CONVERTER_DEFINES_SVH

// check that is held off while reset is asserted
`define RKC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that must also hold during reset
`define RKC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/rkc_pkg.sv @@
// ----------------------------------------------------------------------------
// rkc_pkg
// types, constants and the romaji key rom shared by the converter
// ----------------------------------------------------------------------------
package rkc_pkg;

    localparam int PENDING_DEPTH_DEF = 4;
    localparam int KEY_MAX           = 4;
    localparam int FIFO_DEPTH        = 4;

    // every katakana code point sits in 0x30xx
    localparam logic [5:0] KANA_HI      = 6'h30;
    localparam logic [7:0] KANA_N_LO    = 8'hF3;
    localparam logic [7:0] KANA_TU_LO   = 8'hC3;
    localparam logic [7:0] CH_N         = "n";
    localparam logic [7:0] CH_DASH      = "-";

    typedef struct packed {
        logic       hit;
        logic [7:0] k1;
        logic [7:0] k2;   // zero when only one katakana
    } rom_res_t;

    typedef struct packed {
        logic [1:0] n;
        logic [7:0] c0;
        logic [7:0] c1;
    } push_t;

    typedef enum logic [2:0] {
        FAM_NONE,
        FAM_P,
        FAM_Y,
        FAM_YI0,
        FAM_S,
        FAM_X
    } fam_t;

    function automatic logic is_ending(input logic [7:0] c);
        return c == "a" || c == "i" || c == "u" || c == "e" || c == "o" ||
               c == CH_N || c == CH_DASH;
    endfunction

    function automatic rom_res_t mk(input logic [7:0] a, input logic [7:0] b);
        rom_res_t r;
        r.hit = 1'b1;
        r.k1  = a;
        r.k2  = b;
        return r;
    endfunction

    // key is right-justified, one byte per char, no zero bytes
    function automatic rom_res_t rom_lookup(input logic [31:0] key);
        rom_res_t   r;
        rom_res_t   rf;
        fam_t       fam;
        logic [7:0] b;
        logic [7:0] p [5];
        logic [7:0] ytab [5];
        logic [7:0] stab [5];
        logic [7:0] xtab [5];
        logic [2:0] v;
        logic       vok;
        logic [23:0] pre;
        ytab = '{8'hE3, 8'hA3, 8'hE5, 8'hA7, 8'hE7};
        stab = '{8'hA1, 8'hA3, 8'h00, 8'hA7, 8'hA9};
        xtab = '{8'hA1, 8'hA3, 8'hA5, 8'hA7, 8'hA9};
        fam  = FAM_NONE;
        b    = 8'h00;
        p    = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        pre  = key[31:8];
        vok  = 1'b1;
        unique case (key[7:0])
            "a":     v = 3'd0;
            "i":     v = 3'd1;
            "u":     v = 3'd2;
            "e":     v = 3'd3;
            "o":     v = 3'd4;
            default:
            begin
                v   = 3'd0;
                vok = 1'b0;
            end
        endcase
        unique case (pre)
            "vy": begin fam = FAM_Y; b = 8'hF4; end
            "ky": begin fam = FAM_Y; b = 8'hAD; end
            "gy": begin fam = FAM_Y; b = 8'hAE; end
            "sy": begin fam = FAM_Y; b = 8'hB7; end
            "zy": begin fam = FAM_Y; b = 8'hB8; end
            "ty": begin fam = FAM_Y; b = 8'hC1; end
            "cy": begin fam = FAM_Y; b = 8'hC1; end
            "dy": begin fam = FAM_Y; b = 8'hC2; end
            "th": begin fam = FAM_Y; b = 8'hC6; end
            "dh": begin fam = FAM_Y; b = 8'hC7; end
            "ny": begin fam = FAM_Y; b = 8'hCB; end
            "hy": begin fam = FAM_Y; b = 8'hD2; end
            "by": begin fam = FAM_Y; b = 8'hD3; end
            "py": begin fam = FAM_Y; b = 8'hD4; end
            "my": begin fam = FAM_Y; b = 8'hDF; end
            "ry": begin fam = FAM_Y; b = 8'hEA; end
            "jy": begin fam = FAM_Y; b = 8'hB8; end
            "sh": begin fam = FAM_YI0; b = 8'hB7; end
            "ch": begin fam = FAM_YI0; b = 8'hC1; end
            "j":  begin fam = FAM_YI0; b = 8'hB8; end
            "v":  begin fam = FAM_S; b = 8'hF4; end
            "f":  begin fam = FAM_S; b = 8'hD5; end
            "q":  begin fam = FAM_S; b = 8'hAF; end
            "wh": begin fam = FAM_S; b = 8'hA6; end
            "ts": begin fam = FAM_S; b = 8'hC4; end
            "tw": begin fam = FAM_X; b = 8'hC8; end
            "dw": begin fam = FAM_X; b = 8'hC9; end
            24'h0: begin fam = FAM_P; p = '{8'hA2, 8'hA4, 8'hA6, 8'hA8, 8'hAA}; end
            "x":  begin fam = FAM_P; p = '{8'hA1, 8'hA3, 8'hA5, 8'hA7, 8'hA9}; end
            "l":  begin fam = FAM_P; p = '{8'hA1, 8'hA3, 8'hA5, 8'hA7, 8'hA9}; end
            "ly": begin fam = FAM_P; p = '{8'hE3, 8'hA3, 8'hE5, 8'hA7, 8'hE7}; end
            "xy": begin fam = FAM_P; p = '{8'hE3, 8'hA3, 8'hE5, 8'hA7, 8'hE7}; end
            "k":  begin fam = FAM_P; p = '{8'hAB, 8'hAD, 8'hAF, 8'hB1, 8'hB3}; end
            "g":  begin fam = FAM_P; p = '{8'hAC, 8'hAE, 8'hB0, 8'hB2, 8'hB4}; end
            "s":  begin fam = FAM_P; p = '{8'hB5, 8'hB7, 8'hB9, 8'hBB, 8'hBD}; end
            "c":  begin fam = FAM_P; p = '{8'hAB, 8'hB7, 8'hAF, 8'hBB, 8'hB3}; end
            "z":  begin fam = FAM_P; p = '{8'hB6, 8'hB8, 8'hBA, 8'hBC, 8'hBE}; end
            "t":  begin fam = FAM_P; p = '{8'hBF, 8'hC1, 8'hC4, 8'hC6, 8'hC8}; end
            "d":  begin fam = FAM_P; p = '{8'hC0, 8'hC2, 8'hC5, 8'hC7, 8'hC9}; end
            "n":  begin fam = FAM_P; p = '{8'hCA, 8'hCB, 8'hCC, 8'hCD, 8'hCE}; end
            "h":  begin fam = FAM_P; p = '{8'hCF, 8'hD2, 8'hD5, 8'hD8, 8'hDB}; end
            "b":  begin fam = FAM_P; p = '{8'hD0, 8'hD3, 8'hD6, 8'hD9, 8'hDC}; end
            "p":  begin fam = FAM_P; p = '{8'hD1, 8'hD4, 8'hD7, 8'hDA, 8'hDD}; end
            "m":  begin fam = FAM_P; p = '{8'hDE, 8'hDF, 8'hE0, 8'hE1, 8'hE2}; end
            "r":  begin fam = FAM_P; p = '{8'hE9, 8'hEA, 8'hEB, 8'hEC, 8'hED}; end
            default: fam = FAM_NONE;
        endcase
        rf = '0;
        unique case (fam)
            FAM_P:   rf = mk(p[v], 8'h00);
            FAM_Y:   rf = mk(b, ytab[v]);
            FAM_YI0: rf = mk(b, (v == 3'd1) ? 8'h00 : ytab[v]);
            FAM_S:   rf = mk(b, stab[v]);
            FAM_X:   rf = mk(b, xtab[v]);
            default: rf = '0;
        endcase
        if (!vok)
        begin
            rf = '0;
        end
        unique case (key)
            "t'i":  r = mk(8'hC6, 8'hA3);
            "t'yu": r = mk(8'hC6, 8'hE5);
            "d'i":  r = mk(8'hC7, 8'hA3);
            "d'yu": r = mk(8'hC7, 8'hE5);
            "t'u":  r = mk(8'hC8, 8'hA5);
            "d'u":  r = mk(8'hC9, 8'hA5);
            "fya":  r = mk(8'hD5, 8'hE3);
            "fyu":  r = mk(8'hD5, 8'hE5);
            "fyo":  r = mk(8'hD5, 8'hE7);
            "hwa":  r = mk(8'hD5, 8'hA1);
            "hwi":  r = mk(8'hD5, 8'hA3);
            "hwyu": r = mk(8'hD5, 8'hE5);
            "hwe":  r = mk(8'hD5, 8'hA7);
            "hwo":  r = mk(8'hD5, 8'hA9);
            "wa":   r = mk(8'hEF, 8'h00);
            "wi":   r = mk(8'hA6, 8'hA3);
            "wu":   r = mk(8'hA6, 8'h00);
            "we":   r = mk(8'hA6, 8'hA7);
            "wo":   r = mk(8'hF2, 8'h00);
            "lka":  r = mk(8'hF5, 8'h00);
            "lke":  r = mk(8'hF6, 8'h00);
            "xka":  r = mk(8'hF5, 8'h00);
            "xke":  r = mk(8'hF6, 8'h00);
            "kwa":  r = mk(8'hAF, 8'hA1);
            "kwi":  r = mk(8'hAF, 8'hA3);
            "kwe":  r = mk(8'hAF, 8'hA7);
            "kwo":  r = mk(8'hAF, 8'hA9);
            "ya":   r = mk(8'hE4, 8'h00);
            "yu":   r = mk(8'hE6, 8'h00);
            "ye":   r = mk(8'hA4, 8'hA7);
            "yo":   r = mk(8'hE8, 8'h00);
            "xwa":  r = mk(8'hEE, 8'h00);
            "lwa":  r = mk(8'hEE, 8'h00);
            "xtu":  r = mk(8'hC3, 8'h00);
            "ltu":  r = mk(8'hC3, 8'h00);
            "xtsu": r = mk(8'hC3, 8'h00);
            "ltsu": r = mk(8'hC3, 8'h00);
            "gwa":  r = mk(8'hB0, 8'hA1);
            "nn":   r = mk(8'hF3, 8'h00);
            "xn":   r = mk(8'hF3, 8'h00);
            "-":    r = mk(8'hFC, 8'h00);
            default: r = rf;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/rkc_if.sv @@
// ----------------------------------------------------------------------------
// rkc channel interfaces
// valid/ready channels for romaji bytes in and katakana items out
// ----------------------------------------------------------------------------
interface rkc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       word_start;

    modport source (output valid, output char_byte, output word_start, input ready);
    modport sink   (input valid, input char_byte, input word_start, output ready);
endinterface

interface rkc_out_if;
    logic        valid;
    logic        ready;
    logic [13:0] kana_code;
    logic        last;

    modport source (output valid, output kana_code, output last, input ready);
    modport sink   (input valid, input kana_code, input last, output ready);
endinterface

@@ rtl/core/rkc_row_mem.sv @@
// ----------------------------------------------------------------------------
// rkc_row_mem
// pending byte row memory, registered read with write forwarding
// ----------------------------------------------------------------------------
module rkc_row_mem #(
    parameter int PENDING_DEPTH = rkc_pkg::PENDING_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic                          wr_en,
    input  logic [PENDING_DEPTH-1:0][7:0] wr_row,
    output logic [PENDING_DEPTH-1:0][7:0] rd_row
);
    import rkc_pkg::*;

    logic [PENDING_DEPTH-1:0][7:0] row_mem [1];
    logic [PENDING_DEPTH-1:0][7:0] rd_row_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[0] <= wr_row;
        end
    end

    // a write in the read cycle is seen by that read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row_reg <= wr_en ? wr_row : row_mem[0];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

@@ rtl/core/rkc_engine.sv @@
// ----------------------------------------------------------------------------
// rkc_engine
// takes bytes, updates the pending row and emits matched katakana
// ----------------------------------------------------------------------------
`include "romaji_to_katakana_converter_defines.svh"

module rkc_engine #(
    parameter int PENDING_DEPTH = rkc_pkg::PENDING_DEPTH_DEF,
    parameter int CW            = $clog2(PENDING_DEPTH + 1),
    parameter int IW            = $clog2(PENDING_DEPTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    rkc_in_if.sink                        romaji,
    input  logic                          room,
    output rkc_pkg::push_t                push,
    output logic                          rd_en,
    output logic                          wr_en,
    output logic [PENDING_DEPTH-1:0][7:0] wr_row,
    input  logic [PENDING_DEPTH-1:0][7:0] rd_row
);
    import rkc_pkg::*;

    logic          s1_valid_reg;
    logic [7:0]    c_reg;
    logic          ws_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          dead_reg;
    logic          dead_next;
    logic          fire;
    logic          take;

    logic [CW-1:0] cnt0;
    logic          dead0;
    logic [CW-1:0] ln;
    logic [31:0]   key;
    logic          kz;
    rom_res_t      look;
    logic [7:0]    prev;
    logic [PENDING_DEPTH-1:0][7:0] row_n;

    assign fire         = s1_valid_reg && room;
    assign romaji.ready = !s1_valid_reg || fire;
    assign take         = romaji.valid && romaji.ready;
    assign rd_en        = take;
    assign wr_en        = fire;
    assign wr_row       = row_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            cnt_reg      <= '0;
            dead_reg     <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                cnt_reg  <= cnt_next;
                dead_reg <= dead_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            c_reg  <= romaji.char_byte;
            ws_reg <= romaji.word_start;
        end
    end

    always_comb
    begin
        cnt0      = ws_reg ? '0 : cnt_reg;
        dead0     = ws_reg ? 1'b0 : dead_reg;
        row_n     = rd_row;
        cnt_next  = cnt0;
        dead_next = dead0;
        push      = '0;
        ln        = cnt0 + 1'b1;
        prev      = rd_row[cnt0[IW-1:0] - 1'b1];
        if (cnt0 != CW'(PENDING_DEPTH))
        begin
            row_n[cnt0[IW-1:0]] = c_reg;
        end
        key = '0;
        kz  = 1'b0;
        for (int i = 0; i < KEY_MAX; i++)
        begin
            if (CW'(i) < ln)
            begin
                key = {key[23:0], row_n[i]};
                kz  = kz | (row_n[i] == 8'h00);
            end
        end
        look = rom_lookup(key);
        if (!dead0)
        begin
            if (is_ending(c_reg))
            begin
                if (cnt0 == CW'(PENDING_DEPTH))
                begin
                    dead_next = 1'b1;
                end
                else if (look.hit && !kz && ln <= CW'(KEY_MAX))
                begin
                    cnt_next = '0;
                    push.c0  = look.k1;
                    push.c1  = look.k2;
                    push.n   = (look.k2 != 8'h00) ? 2'd2 : 2'd1;
                end
                else
                begin
                    cnt_next = ln;
                end
            end
            else if (cnt0 == '0)
            begin
                cnt_next = CW'(1);
            end
            else if (prev == CH_N)
            begin
                row_n       = rd_row;
                row_n[0]    = c_reg;
                cnt_next    = CW'(1);
                push.n      = 2'd1;
                push.c0     = KANA_N_LO;
            end
            else if (prev == c_reg)
            begin
                push.n  = 2'd1;
                push.c0 = KANA_TU_LO;
            end
            else if (cnt0 == CW'(PENDING_DEPTH))
            begin
                dead_next = 1'b1;
            end
            else
            begin
                cnt_next = ln;
            end
        end
        if (!fire)
        begin
            push = '0;
        end
    end

    `RKC_ASSERT(a_cnt_range, cnt_reg <= CW'(PENDING_DEPTH), "pending count past depth")
    `RKC_ASSERT(a_dead_quiet, (fire && dead_reg && !ws_reg) |-> (push.n == 2'd0), "output while dead")
    `RKC_ASSERT(a_match_clears, (fire && push.n == 2'd2) |=> (cnt_reg == '0), "two-kana match kept bytes")
    `RKC_ASSERT(a_hold_item, (s1_valid_reg && !room) |=> s1_valid_reg, "item lost while stalled")

endmodule

@@ rtl/core/rkc_out_fifo.sv @@
// ----------------------------------------------------------------------------
// rkc_out_fifo
// small result queue, takes up to two items a cycle, gives one
// ----------------------------------------------------------------------------
`include "romaji_to_katakana_converter_defines.svh"

module rkc_out_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  rkc_pkg::push_t push,
    output logic           room,
    rkc_out_if.source      kana
);
    import rkc_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    logic [8:0]    ent_reg [FIFO_DEPTH];
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] rp_reg;
    logic [PW:0]   cnt_reg;
    logic          pop;

    assign room           = cnt_reg <= (PW+1)'(FIFO_DEPTH - 2);
    assign kana.valid     = cnt_reg != '0;
    assign pop            = kana.valid && kana.ready;
    assign kana.kana_code = {KANA_HI, ent_reg[rp_reg][8:1]};
    assign kana.last      = ent_reg[rp_reg][0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + PW'(push.n);
            rp_reg  <= rp_reg + PW'(pop);
            cnt_reg <= cnt_reg + (PW+1)'(push.n) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            ent_reg[wp_reg] <= {push.c0, push.n == 2'd1};
        end
        if (push.n == 2'd2)
        begin
            ent_reg[wp_reg + 1'b1] <= {push.c1, 1'b1};
        end
    end

    `RKC_ASSERT(a_no_overflow, (push.n != 2'd0) |-> (cnt_reg + (PW+1)'(push.n) <= (PW+1)'(FIFO_DEPTH)), "queue overflow")
    `RKC_ASSERT(a_pair_last, (push.n == 2'd2) |-> (push.c1 != 8'h00), "second kana empty")
    `RKC_ASSERT(a_cnt_bound, cnt_reg <= (PW+1)'(FIFO_DEPTH), "queue count out of range")

endmodule

@@ rtl/core/romaji_to_katakana_converter.sv @@
// ----------------------------------------------------------------------------
// romaji_to_katakana_converter
// romaji bytes in, katakana code points out
// ----------------------------------------------------------------------------
// One romaji byte is taken per cycle while the result queue has room; it
// is held in an engine register, and its katakana (if any) go into the queue.
// Bytes yielding at most one kana run at one per cycle while the output is
// ready; one yielding two outpaces the queue, so the rate is set by the queue
// draining one item a cycle. Pending bytes live in a one-row memory, read
// when a byte is taken and written back when it is passed on; a write is
// forwarded to a read in the same cycle. There is no clearing pass after reset.
module romaji_to_katakana_converter #(
    parameter int PENDING_DEPTH = rkc_pkg::PENDING_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rkc_in_if.sink    romaji,
    rkc_out_if.source kana
);
    import rkc_pkg::*;

    push_t                         push;
    logic                          room;
    logic                          rd_en;
    logic                          wr_en;
    logic [PENDING_DEPTH-1:0][7:0] wr_row;
    logic [PENDING_DEPTH-1:0][7:0] rd_row;

    rkc_row_mem #(
        .PENDING_DEPTH(PENDING_DEPTH)
    ) u_mem (
        .clk    (clk),
        .rd_en  (rd_en),
        .wr_en  (wr_en),
        .wr_row (wr_row),
        .rd_row (rd_row)
    );

    rkc_engine #(
        .PENDING_DEPTH(PENDING_DEPTH)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .romaji (romaji),
        .room   (room),
        .push   (push),
        .rd_en  (rd_en),
        .wr_en  (wr_en),
        .wr_row (wr_row),
        .rd_row (rd_row)
    );

    rkc_out_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .kana  (kana)
    );

endmodule
